### hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bia_pkg.sv
package bia_pkg;

	// id space and bitmap geometry
	localparam int ID_COUNT  = 1024;
	localparam int ID_W      = $clog2(ID_COUNT);
	localparam int MAP_BYTES = (ID_COUNT + 7) / 8;
	localparam int ROW_BYTES = 8;
	localparam int ROW_BITS  = ROW_BYTES * 8;
	localparam int ROWS      = (MAP_BYTES + ROW_BYTES - 1) / ROW_BYTES;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int POS_W     = $clog2(ROW_BITS);
	localparam int HINT_W    = ROW_W + 3;

	localparam logic [7:0] BYTE_FULL = 8'hFF;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic step;
		logic scan;
		logic free_commit;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic hit;
		logic last_row;
		logic out_free;
	} dp_sts_t;

endpackage

### hdl/bia_req_if.sv
interface bia_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [bia_pkg::ID_W-1:0]  target_id;

	modport source (output valid, output opcode, output target_id, input ready);
	modport sink (input valid, input opcode, input target_id, output ready);
endinterface

### hdl/bia_rsp_if.sv
interface bia_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [bia_pkg::ID_W-1:0]  granted_id;
	logic                      status;

	modport source (output valid, output granted_id, output status, input ready);
	modport sink (input valid, input granted_id, input status, output ready);
endinterface

### hdl/bitmap_id_allocator_unit.sv
// bitmap id allocator, 1024 ids kept eight to a byte, one bit per id.
// req channel: opcode 0 allocates the lowest free id at or above the next-fit
// hint byte (no wrap), opcode 1 releases target_id and moves the hint to its byte.
// rsp channel: one word per request, granted_id and status (1 when no free id
// was found from the hint onward; releases always answer id 0, status 0).
// the map is held as 16 rows of 64 bits in a ram with registered read; a
// request is taken only in idle, one at a time, so a new request is not
// accepted until the last result has gone to the rsp register. an allocate
// steps from the hint row onward, one row per cycle through the ram read
// port, until a free id or the map end is found; a release needs no scan.
// rsp is an output register, so the next request is accepted while an earlier
// word still waits; a stalled receiver holds rsp and, once the following
// result is ready, stops the block until the word is taken.
// reset clears per-row valid bits and the hint at once: every id reads free,
// no clearing pass is needed.
module bitmap_id_allocator_unit (
	input logic        clk,
	input logic        arst_n,
	bia_req_if.sink    req,
	bia_rsp_if.source  rsp
);
	import bia_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing
	bia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// map, hint and result registers
	bia_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_opcode     (req.opcode),
		.req_target_id  (req.target_id),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_granted_id (rsp.granted_id),
		.rsp_status     (rsp.status)
	);

endmodule

### hdl/bia_ram.sv
module bia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/bia_dp.sv
`include "assert_macros.svh"

module bia_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bia_pkg::dp_cmd_t          cmd,
	output bia_pkg::dp_sts_t          sts,
	input  logic                      req_opcode,
	input  logic [bia_pkg::ID_W-1:0]  req_target_id,
	input  logic                      rsp_ready,
	output logic                      rsp_valid,
	output logic [bia_pkg::ID_W-1:0]  rsp_granted_id,
	output logic                      rsp_status
);
	import bia_pkg::*;

	logic                op_q;
	logic [ID_W-1:0]     tid_q;
	logic [HINT_W-1:0]   hint_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    chk_row_s1;
	logic                chk_vld_s1;
	logic [ROWS-1:0]     row_vld_q;
	logic [ID_W-1:0]     res_gid_q;
	logic                res_status_q;
	logic                out_vld_q;
	logic [ID_W-1:0]     out_gid_q;
	logic                out_status_q;

	logic                wr_en;
	logic [ROW_BITS-1:0] wr_data;
	logic [ROW_BITS-1:0] rd_data;
	logic [ROW_BITS-1:0] cur_row;
	logic [ROW_BITS-1:0] oob;
	logic [ROW_BITS-1:0] view;
	logic [2:0]          start_off;
	logic                hit;
	logic [2:0]          hit_byte;
	logic [2:0]          hit_bit;
	logic [7:0]          sel_byte;
	logic [ROW_BITS-1:0] alloc_data;
	logic [ROW_BITS-1:0] free_data;
	logic                in_range;
	logic                alloc_we;
	logic                free_we;
	logic [ROW_W-1:0]    tid_row;
	logic [ROW_W-1:0]    hint_row;

	// bitmap rows
	bia_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (chk_row_s1),
		.wr_data (wr_data),
		.rd_addr (row_q),
		.rd_data (rd_data)
	);

	assign tid_row  = ROW_W'(req_target_id >> POS_W);
	assign hint_row = hint_q[HINT_W-1:3];

	// row as seen by the scan: unwritten rows are free, ids past the end are used
	always_comb begin
		cur_row = chk_vld_s1 ? rd_data : '0;
		for (int p = 0; p < ROW_BITS; p++) begin
			oob[p] = (32'(chk_row_s1) * 32'(ROW_BITS) + 32'(p)) >= 32'(ID_COUNT);
		end
		view = cur_row | oob;
	end

	// first byte at or above the start offset that is not full
	always_comb begin
		start_off = (chk_row_s1 == hint_row) ? hint_q[2:0] : 3'd0;
		hit       = 1'b0;
		hit_byte  = 3'd0;
		for (int b = ROW_BYTES - 1; b >= 0; b--) begin
			if (3'(b) >= start_off && view[b*8 +: 8] != BYTE_FULL) begin
				hit      = 1'b1;
				hit_byte = 3'(b);
			end
		end
		sel_byte = view[{hit_byte, 3'b000} +: 8];
		hit_bit  = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!sel_byte[k]) begin
				hit_bit = 3'(k);
			end
		end
	end

	// row update for set and clear
	assign alloc_data = cur_row | (ROW_BITS'(1) << {hit_byte, hit_bit});
	assign free_data  = cur_row & ~(ROW_BITS'(1) << tid_q[POS_W-1:0]);
	assign in_range   = 32'(tid_q) < 32'(ID_COUNT);
	assign alloc_we   = cmd.scan & hit;
	assign free_we    = cmd.free_commit & in_range;
	assign wr_en      = alloc_we | free_we;
	assign wr_data    = alloc_we ? alloc_data : free_data;

	// request capture, read pointer and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			chk_row_s1 <= '0;
			chk_vld_s1 <= 1'b0;
			op_q       <= OP_ALLOC;
			tid_q      <= '0;
		end else begin
			chk_row_s1 <= row_q;
			chk_vld_s1 <= row_vld_q[row_q];
			if (cmd.load_req) begin
				op_q  <= req_opcode;
				tid_q <= req_target_id;
				row_q <= (req_opcode == OP_FREE) ? tid_row : hint_row;
			end else if (cmd.step && row_q != ROW_W'(ROWS - 1)) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	// hint and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q    <= '0;
			row_vld_q <= '0;
		end else begin
			if (alloc_we) begin
				hint_q <= {chk_row_s1, hit_byte};
			end else if (free_we) begin
				hint_q <= HINT_W'(tid_q >> 3);
			end
			if (wr_en) begin
				row_vld_q[chk_row_s1] <= 1'b1;
			end
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			res_gid_q    <= hit ? ID_W'({chk_row_s1, hit_byte, hit_bit}) : '0;
			res_status_q <= hit ? STATUS_OK : STATUS_FULL;
		end else if (cmd.free_commit) begin
			res_gid_q    <= '0;
			res_status_q <= STATUS_OK;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_gid_q    <= res_gid_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp_valid      = out_vld_q;
	assign rsp_granted_id = out_gid_q;
	assign rsp_status     = out_status_q;

	assign sts.is_free  = (op_q == OP_FREE);
	assign sts.hit      = hit;
	assign sts.last_row = (chk_row_s1 == ROW_W'(ROWS - 1));
	assign sts.out_free = !out_vld_q || rsp_ready;

	`CHK_NEXT(a_hint_only_on_write, !wr_en, $stable(hint_q), "hint moved without a map write")
	`CHK_IMPL(a_alloc_sets_one_bit, alloc_we, $countones(wr_data ^ cur_row) == 1,
		"allocate write changed other than one bit")

endmodule

### hdl/bia_ctrl.sv
`include "assert_macros.svh"

module bia_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bia_pkg::dp_sts_t sts,
	output bia_pkg::dp_cmd_t cmd
);
	import bia_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_FREE = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_RD: begin
				cmd.step = !sts.is_free;
				state_d  = sts.is_free ? ST_FREE : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.step = 1'b1;
				if (sts.hit || sts.last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				cmd.free_commit = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CHK_NEXT(a_scan_stops_at_end, state_q == ST_SCAN && sts.last_row, state_q == ST_DONE,
		"scan ran past the last row")
	`CHK_NEXT(a_done_to_idle, state_q == ST_DONE && sts.out_free, state_q == ST_IDLE,
		"result not handed to output register")

endmodule

### tb/sv/tb_bitmap_id_allocator_unit.sv
module tb_bitmap_id_allocator_unit;
	import bia_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            status;
	} grant_reply_t;

	logic clk;
	logic arst_n;

	bia_req_if req_bus();
	bia_rsp_if rsp_bus();

	bitmap_id_allocator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow copy of the id map and the next-fit byte
	logic [7:0]        id_map [MAP_BYTES];
	logic [HINT_W-1:0] next_fit_byte;

	grant_reply_t owed_replies[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_request;
	int hold_left;
	int idle_cycles;
	int errors;
	int alloc_words;
	int release_words;
	int grants_seen;
	int full_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// next-fit allocation / release on the shadow map, returns the word to expect
	function automatic grant_reply_t compute_grant(logic op, logic [ID_W-1:0] tid);
		grant_reply_t r;
		logic [7:0]   v;
		int           b;
		int           k;
		logic         found;
		r.granted_id = '0;
		r.status = STATUS_OK;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			for (b = int'(next_fit_byte); b < MAP_BYTES && !found; b++) begin
				v = id_map[b];
				// bits past the id space read as taken
				for (k = 0; k < 8; k++)
					if (b * 8 + k >= ID_COUNT)
						v[k] = 1'b1;
				if (v != BYTE_FULL) begin
					k = 0;
					while (k < 8 && v[k])
						k++;
					id_map[b][k] = 1'b1;
					next_fit_byte = HINT_W'(b);
					r.granted_id = ID_W'(b * 8 + k);
					found = 1'b1;
				end
			end
			if (!found)
				r.status = STATUS_FULL;
		end else if (int'(tid) < ID_COUNT) begin
			id_map[tid / 8][tid % 8] = 1'b0;
			next_fit_byte = HINT_W'(tid / 8);
		end
		return r;
	endfunction

	// offer one request word, wait for the handshake, then predict its reply
	task automatic send_word(logic op, logic [ID_W-1:0] tid);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.opcode <= op;
		req_bus.target_id <= tid;
		do
			@(posedge clk);
		while (!req_bus.ready);
		owed_replies.push_back(compute_grant(op, tid));
		if (op == OP_ALLOC)
			alloc_words++;
		else
			release_words++;
	endtask

	// ready generation, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// reply checking against the oldest owed word
	always @(posedge clk) begin
		grant_reply_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (owed_replies.size() == 0) begin
				$display("%0t unexpected reply: expected none, actual id %0d status %0b",
					$time, rsp_bus.granted_id, rsp_bus.status);
				errors++;
			end else begin
				want = owed_replies.pop_front();
				if (rsp_bus.granted_id !== want.granted_id) begin
					$display("%0t granted_id mismatch: expected %0d, actual %0d",
						$time, want.granted_id, rsp_bus.granted_id);
					errors++;
				end
				if (rsp_bus.status !== want.status) begin
					$display("%0t status mismatch: expected %0b, actual %0b",
						$time, want.status, rsp_bus.status);
					errors++;
				end
				if (want.status == STATUS_FULL)
					full_seen++;
				else
					grants_seen++;
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// edge ids, no-wrap full report, release of free ids, ignored target on allocate
	task automatic check_directed_cases();
		int n;
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, 10'h3FF);
		send_word(OP_FREE, 10'd0);
		send_word(OP_ALLOC, '0);
		// free id in the top byte pulls the hint to the end
		send_word(OP_FREE, 10'd1023);
		for (n = 0; n < 8; n++)
			send_word(OP_ALLOC, ID_W'(n * 127));
		// low ids are still free but the scan does not wrap
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, 10'd1016);
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, 10'h155);
		send_word(OP_FREE, 10'd5);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, 10'd512);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, 10'h155);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, 10'h2AA);
		send_word(OP_ALLOC, 10'h2AA);
	endtask

	// mixed traffic, allocate share changing every hundred words
	task automatic check_random_traffic(int count);
		int               n;
		int               tries;
		int               alloc_pct;
		logic             op;
		logic [ID_W-1:0]  tid;
		alloc_pct = 85;
		for (n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: alloc_pct = 50;
					1: alloc_pct = 85;
					default: alloc_pct = 100;
				endcase
			end
			tid = ID_W'($urandom);
			if ($urandom_range(0, 99) < alloc_pct) begin
				op = OP_ALLOC;
			end else begin
				op = OP_FREE;
				// mostly release ids that are held, sometimes top-range or any id
				case ($urandom_range(0, 9))
					0, 1: tid = ID_W'($urandom_range(ID_COUNT - 64, ID_COUNT - 1));
					2: ;
					default:
						for (tries = 0; tries < 24 && !id_map[tid / 8][tid % 8]; tries++)
							tid = ID_W'($urandom);
				endcase
			end
			send_word(op, tid);
		end
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic check_full_backpressure();
		int n;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = HOLD_CYCLES;
		for (n = 0; n < 24; n++)
			send_word(n % 3 == 2 ? OP_FREE : OP_ALLOC, ID_W'($urandom));
	endtask

	// sender stops until every owed reply is back, then resumes
	task automatic check_drain_pause();
		int n;
		send_idle_pct = 0;
		recv_idle_pct = 30;
		for (n = 0; n < 12; n++)
			send_word(n % 2 ? OP_FREE : OP_ALLOC, ID_W'($urandom));
		req_bus.valid <= 1'b0;
		while (owed_replies.size() != 0)
			@(posedge clk);
		for (n = 0; n < 12; n++)
			send_word(n % 4 == 3 ? OP_FREE : OP_ALLOC, ID_W'($urandom));
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.opcode = OP_ALLOC;
		req_bus.target_id = '0;
		rsp_bus.ready = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 83;
		hold_request = 0;
		hold_left = 0;
		idle_cycles = 0;
		errors = 0;
		alloc_words = 0;
		release_words = 0;
		grants_seen = 0;
		full_seen = 0;
		for (n = 0; n < MAP_BYTES; n++)
			id_map[n] = '0;
		next_fit_byte = '0;

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		check_directed_cases();
		check_random_traffic(420);
		send_idle_pct = 83;
		recv_idle_pct = 12;
		check_random_traffic(420);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		check_random_traffic(420);
		check_full_backpressure();
		check_drain_pause();

		// drain
		req_bus.valid <= 1'b0;
		recv_idle_pct = 0;
		while (owed_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d allocate and %0d release words under mixed stalls",
			alloc_words, release_words);
		$display("replies checked: %0d successful, %0d reporting no free id from the hint",
			grants_seen, full_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
